@@ design/action_deadline_supervisor_defines.svh @@
// Assertion macros used by the checker file.
`ifndef ACTION_DEADLINE_SUPERVISOR_DEFINES_SVH
`define ACTION_DEADLINE_SUPERVISOR_DEFINES_SVH

// Checked while reset is released.
`define ADSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ADSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/adsv_pkg.sv @@
`timescale 1ns / 1ps
package adsv_pkg;

  localparam int TIME_BITS = 48;
  localparam int EP_BITS   = 53;
  localparam int SEQ_BITS  = 31;
  localparam int VEL_BITS  = 32;
  localparam int CFG_BITS  = 32;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_OBSERVE = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_REPLY  = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_OBS  = 2'd2;

  localparam logic [1:0] CAUSE_ACCEPT = 2'd0;
  localparam logic [1:0] CAUSE_HOLD   = 2'd1;
  localparam logic [1:0] CAUSE_SAFE   = 2'd2;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_DEADLINE = 2'd1;
  localparam logic [1:0] CFG_MISSES   = 2'd2;

  localparam logic [31:0] SRC_NONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} adsv_state_t;

  typedef struct packed {
    logic [2:0]                operation;
    logic [EP_BITS-1:0]        episode_id;
    logic [SEQ_BITS-1:0]       reply_sequence;
    logic signed [VEL_BITS-1:0] reply_velocity_x;
    logic signed [VEL_BITS-1:0] reply_velocity_y;
    logic [TIME_BITS-1:0]      sim_time;
    logic [TIME_BITS-1:0]      wall_time;
    logic                      state_valid;
    logic                      is_resimulation;
  } adsv_in_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [EP_BITS-1:0]        out_episode;
    logic [SEQ_BITS-1:0]       sequence_res;
    logic                      has_previous;
    logic signed [31:0]        previous_sequence;
    logic signed [VEL_BITS-1:0] velocity_x;
    logic signed [VEL_BITS-1:0] velocity_y;
    logic [1:0]                cause;
    logic                      last;
  } adsv_out_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] dividend;
    logic [CFG_BITS-1:0]  divisor;
  } adsv_div_req_t;

  typedef struct packed {
    logic                done;
    logic [CFG_BITS-1:0] rem;
  } adsv_div_rsp_t;

endpackage

@@ design/adsv_div.sv @@
`timescale 1ns / 1ps
module adsv_div
  import adsv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  adsv_div_req_t req,
  output adsv_div_rsp_t rsp
);

  localparam int CW = $clog2(TIME_BITS + 1);

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] num_r, num_nxt;
  logic [CFG_BITS-1:0]  rem_r, rem_nxt;
  logic [CFG_BITS-1:0]  dsr_r, dsr_nxt;
  logic                 done_r, done_nxt;
  logic [CFG_BITS:0]    trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[TIME_BITS-1]};
    if (req.start) begin
      cnt_nxt = CW'(TIME_BITS);
      num_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CFG_BITS'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[CFG_BITS-1:0];
      end
      num_nxt  = {num_r[TIME_BITS-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ design/action_deadline_supervisor.sv @@
`timescale 1ns / 1ps
// Supervises a request/response control link. Each accepted beat is handled
// alone: start and stop beats only update state; an observe beat that finds
// the slot grid already set waits for the slot remainder from a restoring
// divider that retires one time bit per cycle. Up to two result beats follow,
// an expiry command before the observation request; no input beat is taken
// until the last one has gone.
module action_deadline_supervisor
  import adsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  adsv_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output adsv_out_t           out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  adsv_state_t state_r, state_nxt;

  logic [31:0] interval_r, deadline_r;
  logic [7:0]  misses_r;

  logic                 enabled_r, enabled_nxt;
  logic [EP_BITS-1:0]   episode_r, episode_nxt;
  logic                 has_epoch_r, has_epoch_nxt;
  logic [TIME_BITS-1:0] epoch_r, epoch_nxt;
  logic [TIME_BITS-1:0] boundary_r, boundary_nxt;
  logic                 outstanding_r, outstanding_nxt;
  logic                 answered_r, answered_nxt;
  logic [TIME_BITS-1:0] rdeadline_r, rdeadline_nxt;
  logic [SEQ_BITS-1:0]  next_seq_r, next_seq_nxt;
  logic [SEQ_BITS-1:0]  pend_seq_r, pend_seq_nxt;
  logic [VEL_BITS-1:0]  avx_r, avx_nxt;
  logic [VEL_BITS-1:0]  avy_r, avy_nxt;
  logic [31:0]          asrc_r, asrc_nxt;
  logic [7:0]           miss_r, miss_nxt;
  logic [TIME_BITS-1:0] base_r, base_nxt;
  adsv_out_t            res_a_r, res_a_nxt, res_b_r, res_b_nxt;
  logic                 two_r, two_nxt;
  logic                 idx_r, idx_nxt;

  adsv_div_req_t div_req;
  adsv_div_rsp_t div_rsp;

  logic [31:0]          interval;
  logic                 accept;
  logic [7:0]           miss_inc;
  logic                 stop_now;
  logic                 obs_go;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS:0]   sum_b, sum_d, sum_f;
  logic [TIME_BITS-1:0] slot_base;
  adsv_out_t            cmd, obs;

  adsv_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign interval = (interval_r == '0) ? 32'd1 : interval_r;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_data = idx_r ? res_b_r : res_a_r;

  always_comb begin
    state_nxt       = state_r;
    enabled_nxt     = enabled_r;
    episode_nxt     = episode_r;
    has_epoch_nxt   = has_epoch_r;
    epoch_nxt       = epoch_r;
    boundary_nxt    = boundary_r;
    outstanding_nxt = outstanding_r;
    answered_nxt    = answered_r;
    rdeadline_nxt   = rdeadline_r;
    next_seq_nxt    = next_seq_r;
    pend_seq_nxt    = pend_seq_r;
    avx_nxt         = avx_r;
    avy_nxt         = avy_r;
    asrc_nxt        = asrc_r;
    miss_nxt        = miss_r;
    base_nxt        = base_r;
    res_a_nxt       = res_a_r;
    res_b_nxt       = res_b_r;
    two_nxt         = two_r;
    idx_nxt         = idx_r;

    miss_inc = (miss_r == 8'hFF) ? miss_r : miss_r + 8'd1;
    stop_now = (miss_inc >= misses_r);

    cmd                   = '0;
    cmd.kind              = KIND_CMD;
    cmd.sequence_res      = pend_seq_r;
    cmd.velocity_x        = stop_now ? '0 : avx_r;
    cmd.velocity_y        = stop_now ? '0 : avy_r;
    cmd.cause             = stop_now ? CAUSE_SAFE : CAUSE_HOLD;
    cmd.last              = 1'b1;

    obs                   = '0;
    obs.kind              = KIND_OBS;
    obs.out_episode       = episode_r;
    obs.sequence_res      = next_seq_r;
    obs.has_previous      = (next_seq_r != '0);
    obs.previous_sequence = asrc_r;
    obs.velocity_x        = avx_r;
    obs.velocity_y        = avy_r;
    obs.last              = 1'b1;

    obs_go = enabled_r && in_data.state_valid && !in_data.is_resimulation &&
             !(has_epoch_r && (in_data.sim_time < boundary_r));
    elapsed = (in_data.sim_time > epoch_r) ? in_data.sim_time - epoch_r : '0;
    sum_b = {1'b0, in_data.sim_time} + {{(TIME_BITS-32){1'b0}}, interval};
    sum_d = {1'b0, in_data.wall_time} + {{(TIME_BITS-32){1'b0}}, deadline_r};
    slot_base = base_r - {{(TIME_BITS-32){1'b0}}, div_rsp.rem};
    sum_f = {1'b0, slot_base} + {{(TIME_BITS-32){1'b0}}, interval};

    div_req.start    = 1'b0;
    div_req.dividend = elapsed;
    div_req.divisor  = interval;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_START, OP_STOP: begin
              enabled_nxt     = (in_data.operation == OP_START);
              episode_nxt     = (in_data.operation == OP_START) ? in_data.episode_id : '0;
              if (in_data.operation == OP_START) begin
                epoch_nxt     = '0;
                boundary_nxt  = '0;
                rdeadline_nxt = '0;
              end
              has_epoch_nxt   = 1'b0;
              outstanding_nxt = 1'b0;
              answered_nxt    = 1'b0;
              avx_nxt         = '0;
              avy_nxt         = '0;
              asrc_nxt        = SRC_NONE;
              next_seq_nxt    = '0;
              pend_seq_nxt    = '0;
              miss_nxt        = '0;
            end
            OP_OBSERVE: begin
              if (obs_go) begin
                two_nxt = outstanding_r;
                idx_nxt = 1'b0;
                if (outstanding_r) begin
                  cmd.last  = 1'b0;
                  res_a_nxt = cmd;
                  res_b_nxt = obs;
                  miss_nxt  = miss_inc;
                  if (stop_now) begin
                    avx_nxt  = '0;
                    avy_nxt  = '0;
                    asrc_nxt = {1'b0, pend_seq_r};
                  end
                end else begin
                  res_a_nxt = obs;
                end
                if ((outstanding_r && stop_now) || (asrc_r == SRC_NONE)) begin
                  if (asrc_r == SRC_NONE) begin
                    asrc_nxt = {1'b0, next_seq_r};
                  end
                end
                next_seq_nxt    = next_seq_r + SEQ_BITS'(1);
                pend_seq_nxt    = next_seq_r;
                outstanding_nxt = 1'b1;
                answered_nxt    = 1'b0;
                rdeadline_nxt   = sum_d[TIME_BITS] ? TIME_MAX : sum_d[TIME_BITS-1:0];
                if (!has_epoch_r) begin
                  has_epoch_nxt = 1'b1;
                  epoch_nxt     = in_data.sim_time;
                  boundary_nxt  = sum_b[TIME_BITS] ? TIME_MAX : sum_b[TIME_BITS-1:0];
                  state_nxt     = ST_EMIT;
                end else begin
                  base_nxt      = (in_data.sim_time > epoch_r) ? in_data.sim_time : epoch_r;
                  div_req.start = 1'b1;
                  state_nxt     = ST_DIV;
                end
              end
            end
            OP_TICK: begin
              if (enabled_r && outstanding_r && (in_data.wall_time >= rdeadline_r)) begin
                outstanding_nxt = 1'b0;
                answered_nxt    = 1'b0;
                miss_nxt        = miss_inc;
                if (stop_now) begin
                  avx_nxt  = '0;
                  avy_nxt  = '0;
                  asrc_nxt = {1'b0, pend_seq_r};
                end
                res_a_nxt = cmd;
                two_nxt   = 1'b0;
                idx_nxt   = 1'b0;
                state_nxt = ST_EMIT;
              end
            end
            OP_REPLY: begin
              if (enabled_r && outstanding_r && !answered_r &&
                  (in_data.episode_id == episode_r) &&
                  (in_data.reply_sequence == pend_seq_r) &&
                  (in_data.wall_time < rdeadline_r)) begin
                outstanding_nxt = 1'b0;
                answered_nxt    = 1'b1;
                miss_nxt        = '0;
                avx_nxt         = in_data.reply_velocity_x;
                avy_nxt         = in_data.reply_velocity_y;
                asrc_nxt        = {1'b0, in_data.reply_sequence};
                res_a_nxt              = '0;
                res_a_nxt.kind         = KIND_CMD;
                res_a_nxt.sequence_res = in_data.reply_sequence;
                res_a_nxt.velocity_x   = in_data.reply_velocity_x;
                res_a_nxt.velocity_y   = in_data.reply_velocity_y;
                res_a_nxt.cause        = CAUSE_ACCEPT;
                res_a_nxt.last         = 1'b1;
                two_nxt   = 1'b0;
                idx_nxt   = 1'b0;
                state_nxt = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          boundary_nxt = sum_f[TIME_BITS] ? TIME_MAX : sum_f[TIME_BITS-1:0];
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (two_r && !idx_r) begin
            idx_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      interval_r    <= 32'd100000;
      deadline_r    <= 32'd100000;
      misses_r      <= 8'd3;
      enabled_r     <= 1'b0;
      episode_r     <= '0;
      has_epoch_r   <= 1'b0;
      epoch_r       <= '0;
      boundary_r    <= '0;
      outstanding_r <= 1'b0;
      answered_r    <= 1'b0;
      rdeadline_r   <= '0;
      next_seq_r    <= '0;
      pend_seq_r    <= '0;
      avx_r         <= '0;
      avy_r         <= '0;
      asrc_r        <= SRC_NONE;
      miss_r        <= '0;
      two_r         <= 1'b0;
      idx_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      enabled_r     <= enabled_nxt;
      episode_r     <= episode_nxt;
      has_epoch_r   <= has_epoch_nxt;
      epoch_r       <= epoch_nxt;
      boundary_r    <= boundary_nxt;
      outstanding_r <= outstanding_nxt;
      answered_r    <= answered_nxt;
      rdeadline_r   <= rdeadline_nxt;
      next_seq_r    <= next_seq_nxt;
      pend_seq_r    <= pend_seq_nxt;
      avx_r         <= avx_nxt;
      avy_r         <= avy_nxt;
      asrc_r        <= asrc_nxt;
      miss_r        <= miss_nxt;
      two_r         <= two_nxt;
      idx_r         <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_data;
          CFG_DEADLINE: deadline_r <= cfg_data;
          CFG_MISSES:   misses_r   <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
    base_r  <= base_nxt;
    res_a_r <= res_a_nxt;
    res_b_r <= res_b_nxt;
  end

endmodule

@@ design/adsv_checker.sv @@
`timescale 1ns / 1ps
`include "action_deadline_supervisor_defines.svh"
module adsv_checker
  import adsv_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input adsv_out_t out_data
);

  `ADSV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "Result beat dropped while stalled.")
  `ADSV_ASSERT(a_busy_out, out_valid |-> in_stall, "Input taken while a result is pending.")
  `ADSV_ASSERT(a_last_end, out_valid && !out_stall && out_data.last |=> !out_valid, "Result beat after the last one.")
  `ADSV_ASSERT(a_obs_last, out_valid && out_data.kind == KIND_OBS |-> out_data.last, "Observation request is not the final beat.")
  `ADSV_ASSERT_ALWAYS(a_safe_zero, out_valid && out_data.kind == KIND_CMD && out_data.cause == CAUSE_SAFE |-> out_data.velocity_x == '0 && out_data.velocity_y == '0, "Safe stop with nonzero velocity.")

endmodule

bind action_deadline_supervisor adsv_checker u_adsv_checker (.*);
